// ===== sv/wtlc_pkg.sv =====
// ----------------------------------------------------------------------------
// wtlc_pkg
// Types and codes shared by the write-through LRU block cache tag engine.
// ----------------------------------------------------------------------------
package wtlc_pkg;

  // index and rank fields in the chain and update structs are sized for the largest slot count
  localparam int IDX_W = 6;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_SYN   = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  // ignored request kind, leaves the state alone
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_SYN   = 2'd2;
  localparam logic [1:0] ACC_WRITE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] blk_num;
    logic        lower_synthetic;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot_index;
    logic        evicted_valid;
    logic [31:0] evicted_number;
    logic [1:0]  lower_access;
    logic        filled;
  } rsp_t;

  // lookup result rippled from cell to cell
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_rank;
    logic             hit_syn;
    logic [IDX_W-1:0] vic_idx;
    logic             vic_valid;
    logic [31:0]      vic_tag;
  } chain_t;

  // update broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] sel;
    logic             tag_we;
    logic [31:0]      tag;
    logic             valid_we;
    logic             valid_val;
    logic             syn_we;
    logic             syn_val;
    logic             move;
    logic [IDX_W-1:0] mv_rank;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_t;

endpackage

// ===== sv/wtlc_cell.sv =====
// ----------------------------------------------------------------------------
// wtlc_cell
// One cache slot: tag, valid, synthetic mark and recency rank. Adds its
// match and victim status to the lookup chain and applies the update.
// ----------------------------------------------------------------------------
module wtlc_cell #(
  parameter int SLOT_COUNT = 16,
  parameter int IDX        = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [31:0]     key,
  input  wtlc_pkg::chain_t cin,
  output wtlc_pkg::chain_t cout,
  input  wtlc_pkg::upd_t  upd
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] RANK_MAX = IW'(SLOT_COUNT - 1);
  localparam logic [wtlc_pkg::IDX_W-1:0] MY_IDX = wtlc_pkg::IDX_W'(IDX);

  logic [31:0]   tag;
  logic          valid;
  logic          syn;
  logic [IW-1:0] rank;
  logic          me;

  assign me = (upd.sel == MY_IDX);

  always_comb begin
    cout = cin;
    if (!cin.found && valid && (tag == key)) begin
      cout.found    = 1'b1;
      cout.hit_idx  = MY_IDX;
      cout.hit_rank = wtlc_pkg::IDX_W'(rank);
      cout.hit_syn  = syn;
    end
    if (rank == '0) begin
      cout.vic_idx   = MY_IDX;
      cout.vic_valid = valid;
      cout.vic_tag   = tag;
    end
  end

  // tag has no reset, it is only read while valid
  always_ff @(posedge clk) begin
    if (upd.en && me && upd.tag_we) begin
      tag <= upd.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      syn   <= 1'b0;
      rank  <= IW'(IDX);
    end else if (upd.en) begin
      if (me && upd.valid_we) begin
        valid <= upd.valid_val;
      end
      if (me && upd.syn_we) begin
        syn <= upd.syn_val;
      end
      if (upd.move) begin
        if (me) begin
          rank <= RANK_MAX;
        end else if (wtlc_pkg::IDX_W'(rank) > upd.mv_rank) begin
          rank <= rank - 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/write_through_lru_block_cache.sv =====
// ----------------------------------------------------------------------------
// write_through_lru_block_cache
// Tag and recency engine of a fully associative write-through block cache
// with LRU replacement, built as a row of slot cells.
//
//   channel  handshake          payload
//   req      req_valid/stall    wtlc_pkg::req_t  (mode, block, lower synthetic)
//   rsp      rsp_valid/stall    wtlc_pkg::rsp_t  (one result per request)
//
// a request passes through a lookup state that ripples the tag compare and victim
// search down the cell row, then an update state that broadcasts the update to all cells
// a new request is taken in the update state, so the next request is accepted as the
// last one finishes, provided the response register drains
// reset (synchronous) clears valid and synthetic marks, ranks start at slot
// index; no clearing pass
// a stalled response holds the update cycle until the response slot frees
// ----------------------------------------------------------------------------
module write_through_lru_block_cache #(
  parameter int SLOT_COUNT = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  wtlc_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output wtlc_pkg::rsp_t  rsp
);

  wtlc_pkg::state_t state, state_next;
  wtlc_pkg::req_t   cur;
  wtlc_pkg::chain_t lk;
  wtlc_pkg::chain_t chain [SLOT_COUNT+1];
  wtlc_pkg::upd_t   upd;
  wtlc_pkg::rsp_t   res;
  logic             out_free;
  logic             req_take;
  logic             finish;
  logic             fill;
  logic [31:0]      slot_ext;

  assign chain[0] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    wtlc_cell #(
      .SLOT_COUNT(SLOT_COUNT),
      .IDX       (i)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .key (cur.blk_num),
      .cin (chain[i]),
      .cout(chain[i+1]),
      .upd (upd)
    );
  end

  assign out_free = !rsp_valid || !rsp_stall;
  assign req_take = req_valid && !req_stall;

  always_comb begin
    req_stall  = 1'b1;
    finish     = 1'b0;
    state_next = state;
    unique case (state)
      wtlc_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = wtlc_pkg::ST_LOOK;
        end
      end
      wtlc_pkg::ST_LOOK: begin
        state_next = wtlc_pkg::ST_UPD;
      end
      wtlc_pkg::ST_UPD: begin
        if (out_free) begin
          finish     = 1'b1;
          req_stall  = 1'b0;
          state_next = req_valid ? wtlc_pkg::ST_LOOK : wtlc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wtlc_pkg::ST_IDLE;
      end
    endcase
  end

  // decide the update and the result from the latched lookup
  always_comb begin
    upd      = '0;
    res      = '0;
    fill     = 1'b0;
    slot_ext = '0;
    upd.tag  = cur.blk_num;
    if (cur.mode != wtlc_pkg::MODE_RSVD) begin
      upd.en = finish;
      if (lk.found) begin
        res.hit     = 1'b1;
        slot_ext    = 32'(lk.hit_idx);
        upd.sel     = lk.hit_idx;
        upd.move    = 1'b1;
        upd.mv_rank = lk.hit_rank;
        if (cur.mode == wtlc_pkg::MODE_READ && lk.hit_syn) begin
          upd.syn_we       = 1'b1;
          res.lower_access = wtlc_pkg::ACC_READ;
        end else if (cur.mode == wtlc_pkg::MODE_WRITE) begin
          res.lower_access = wtlc_pkg::ACC_WRITE;
        end
      end else begin
        fill = !(cur.mode == wtlc_pkg::MODE_READ && cur.lower_synthetic);
        res.evicted_valid  = lk.vic_valid;
        res.evicted_number = lk.vic_valid ? lk.vic_tag : 32'd0;
        unique case (cur.mode)
          wtlc_pkg::MODE_READ: res.lower_access = wtlc_pkg::ACC_READ;
          wtlc_pkg::MODE_SYN:  res.lower_access = wtlc_pkg::ACC_SYN;
          default:             res.lower_access = wtlc_pkg::ACC_WRITE;
        endcase
        res.filled    = fill;
        upd.sel       = lk.vic_idx;
        upd.tag_we    = fill;
        upd.valid_we  = 1'b1;
        upd.valid_val = fill;
        upd.syn_we    = 1'b1;
        upd.syn_val   = fill && (cur.mode == wtlc_pkg::MODE_SYN);
        // victim always holds rank zero
        upd.move      = fill;
        upd.mv_rank   = '0;
        if (fill) begin
          slot_ext = 32'(lk.vic_idx);
        end
      end
    end
    res.slot_index = slot_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wtlc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cur <= req;
    end
    if (state == wtlc_pkg::ST_LOOK) begin
      lk <= chain[SLOT_COUNT];
    end
    if (finish) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_rsp_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == wtlc_pkg::ST_UPD))
    else $error("response raised outside update cycle");

  a_take_to_look: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == wtlc_pkg::ST_LOOK))
    else $error("accepted request did not start a lookup");

  a_hit_no_fill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.hit && (rsp.filled || rsp.evicted_valid)))
    else $error("hit response also filled or evicted");

  a_stall_holds_upd: assert property (@(posedge clk) disable iff (rst)
    (state == wtlc_pkg::ST_UPD && rsp_valid && rsp_stall)
      |=> (state == wtlc_pkg::ST_UPD))
    else $error("update completed while response slot was busy");
`endif

endmodule

// ===== tb/write_through_lru_block_cache_checker.sv =====
// ----------------------------------------------------------------------------
// write_through_lru_block_cache_checker
// Watches the request and response channels of the LRU block cache tag
// engine, keeps its own copy of the tags, marks and recency ranks, works out
// the response of every accepted request and compares each response field.
// ----------------------------------------------------------------------------
module write_through_lru_block_cache_checker #(
  parameter int SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  wtlc_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  wtlc_pkg::rsp_t rsp,
  output int             fails,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] slot_tag [SLOTS];
  logic        slot_valid [SLOTS];
  logic        slot_syn [SLOTS];
  int          slot_rank [SLOTS];

  wtlc_pkg::rsp_t due_rsp [$];

  function automatic void clear_slots();
    for (int i = 0; i < SLOTS; i++) begin
      slot_tag[i] = '0;
      slot_valid[i] = 1'b0;
      slot_syn[i] = 1'b0;
      slot_rank[i] = i;
    end
  endfunction

  function automatic void touch(int s);
    int old_rank;
    old_rank = slot_rank[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_rank[i] > old_rank) slot_rank[i]--;
    end
    slot_rank[s] = SLOTS - 1;
  endfunction

  // lookup, eviction and fill for one request; updates the slot state
  function automatic wtlc_pkg::rsp_t lru_access(wtlc_pkg::req_t r);
    wtlc_pkg::rsp_t o;
    int   s;
    int   victim;
    bit   found;
    o = '0;
    s = 0;
    victim = 0;
    found = 1'b0;
    if (r.mode == wtlc_pkg::MODE_RSVD) return o;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && slot_valid[i] && slot_tag[i] == r.blk_num) begin
        found = 1'b1;
        s = i;
      end
    end
    if (found) begin
      o.hit = 1'b1;
      o.slot_index = 4'(s);
      touch(s);
      if (r.mode == wtlc_pkg::MODE_READ) begin
        // a synthetic entry is re-read below and loses its mark
        if (slot_syn[s]) begin
          o.lower_access = wtlc_pkg::ACC_READ;
          slot_syn[s] = 1'b0;
        end
      end else if (r.mode == wtlc_pkg::MODE_WRITE) begin
        o.lower_access = wtlc_pkg::ACC_WRITE;
      end
    end else begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (slot_rank[i] == 0) victim = i;
      end
      if (slot_valid[victim]) begin
        o.evicted_valid = 1'b1;
        o.evicted_number = slot_tag[victim];
        slot_valid[victim] = 1'b0;
        slot_syn[victim] = 1'b0;
      end
      case (r.mode)
        wtlc_pkg::MODE_READ: o.lower_access = wtlc_pkg::ACC_READ;
        wtlc_pkg::MODE_SYN:  o.lower_access = wtlc_pkg::ACC_SYN;
        default:             o.lower_access = wtlc_pkg::ACC_WRITE;
      endcase
      if (!(r.mode == wtlc_pkg::MODE_READ && r.lower_synthetic)) begin
        o.filled = 1'b1;
        o.slot_index = 4'(victim);
        slot_tag[victim] = r.blk_num;
        slot_valid[victim] = 1'b1;
        slot_syn[victim] = (r.mode == wtlc_pkg::MODE_SYN);
        touch(victim);
      end
    end
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    wtlc_pkg::rsp_t want;
    if (rst) begin
      fails = 0;
      clear_slots();
      due_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          $error("response transfer with no request outstanding");
          fails++;
        end else begin
          want = due_rsp.pop_front();
          check_field("hit", 32'(want.hit), 32'(rsp.hit));
          check_field("slot_index", 32'(want.slot_index), 32'(rsp.slot_index));
          check_field("evicted_valid", 32'(want.evicted_valid), 32'(rsp.evicted_valid));
          check_field("evicted_number", want.evicted_number, rsp.evicted_number);
          check_field("lower_access", 32'(want.lower_access), 32'(rsp.lower_access));
          check_field("filled", 32'(want.filled), 32'(rsp.filled));
        end
      end
      if (req_valid && !req_stall) due_rsp.push_back(lru_access(req));
    end
    outstanding <= due_rsp.size();
  end

endmodule

// ===== tb/write_through_lru_block_cache_tb.sv =====
// ----------------------------------------------------------------------------
// write_through_lru_block_cache_tb
// Drives the LRU block cache tag engine with a directed sequence of hits,
// misses, synthetic entries and evictions, then bursts of random requests
// over small and large working sets, with a randomly stalling receiver.
// ----------------------------------------------------------------------------
module write_through_lru_block_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int RANDOM_ITEMS = 700;
  localparam int POOL_SIZE = 40;
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  wtlc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  wtlc_pkg::rsp_t rsp;

  int fails;
  int outstanding;
  int cycles = 0;

  logic [31:0] block_pool [POOL_SIZE];

  write_through_lru_block_cache #(
    .SLOT_COUNT(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  write_through_lru_block_cache_checker #(
    .SLOTS(SLOTS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fails      (fails),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** write_through_lru_block_cache: FAILED **");
      $finish;
    end
  end

  // receiver: phases of free flow, light stalling and heavy stalling
  initial begin : rsp_stall_gen
    int kind;
    int phase_len;
    forever begin
      kind = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        @(posedge clk);
        case (kind)
          0:       rsp_stall <= 1'b0;
          1:       rsp_stall <= ($urandom_range(0, 2) == 0);
          default: rsp_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic wtlc_pkg::req_t make_req(logic [1:0] m, logic [31:0] n, logic ls);
    wtlc_pkg::req_t r;
    r.mode = m;
    r.blk_num = n;
    r.lower_synthetic = ls;
    return r;
  endfunction

  // small windows mostly hit, windows above the slot count keep evicting
  function automatic wtlc_pkg::req_t random_req(int window);
    wtlc_pkg::req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) r.mode = wtlc_pkg::MODE_READ;
    else if (pick < 65) r.mode = wtlc_pkg::MODE_SYN;
    else if (pick < 95) r.mode = wtlc_pkg::MODE_WRITE;
    else r.mode = wtlc_pkg::MODE_RSVD;
    if ($urandom_range(0, 9) == 0) r.blk_num = $urandom();
    else r.blk_num = block_pool[$urandom_range(0, window - 1)];
    r.lower_synthetic = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  task automatic send(wtlc_pkg::req_t r);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic pause(int n);
    repeat (n) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int   counted;
    int   burst_len;
    int   window;
    wtlc_pkg::req_t r;
    block_pool[0] = '0;
    block_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) block_pool[i] = $urandom();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: fills, hits, synthetic marks, no-fill read, unused mode
    send(make_req(wtlc_pkg::MODE_READ, 32'h0000_0000, 1'b0));
    send(make_req(wtlc_pkg::MODE_READ, 32'h0000_0000, 1'b0));
    send(make_req(wtlc_pkg::MODE_WRITE, 32'hffff_ffff, 1'b0));
    pause(3);
    send(make_req(wtlc_pkg::MODE_SYN, 32'h1234_5678, 1'b0));
    send(make_req(wtlc_pkg::MODE_WRITE, 32'h1234_5678, 1'b0));
    send(make_req(wtlc_pkg::MODE_READ, 32'h1234_5678, 1'b0));
    send(make_req(wtlc_pkg::MODE_READ, 32'h1234_5678, 1'b0));
    send(make_req(wtlc_pkg::MODE_SYN, 32'h0000_0000, 1'b1));
    send(make_req(wtlc_pkg::MODE_READ, 32'haaaa_5555, 1'b1));
    send(make_req(wtlc_pkg::MODE_RSVD, 32'hffff_ffff, 1'b1));
    send(make_req(wtlc_pkg::MODE_WRITE, 32'hffff_ffff, 1'b1));
    // fill every slot and run past it so the least recent entry gets evicted
    for (int i = 0; i < 14; i++) begin
      send(make_req(wtlc_pkg::MODE_WRITE, 32'h8000_0000 + i, i[0]));
      if (i % 5 == 4) pause(1);
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       window = 8;
        1:       window = 14;
        2:       window = 20;
        default: window = POOL_SIZE;
      endcase
      repeat (burst_len) begin
        r = random_req(window);
        send(r);
        if (r.mode != wtlc_pkg::MODE_RSVD) counted++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
    end
    req_valid <= 1'b0;

    // let the count include the last transfer before waiting on it
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("** write_through_lru_block_cache: PASSED **");
    end else begin
      $display("** write_through_lru_block_cache: FAILED **");
    end
    $finish;
  end

endmodule
